FILE: sv/kfj_pkg.sv
package kfj_pkg;

  // Default arithmetic format
  localparam int WORD_BITS_DEF = 32;
  localparam int FRAC_BITS_DEF = 16;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_Q_POS  = 3'd0,
    CFG_Q_VEL  = 3'd1,
    CFG_Q_ACC  = 3'd2,
    CFG_Q_JERK = 3'd3,
    CFG_R_MEAS = 3'd4,
    CFG_P_INIT = 3'd5
  } kfj_cfg_e;

  // Register reset values
  localparam logic [30:0] Q_POS_RST  = 31'd6554;
  localparam logic [30:0] Q_VEL_RST  = 31'd65536;
  localparam logic [30:0] Q_ACC_RST  = 31'd65536;
  localparam logic [30:0] Q_JERK_RST = 31'd65536;
  localparam logic [30:0] R_MEAS_RST = 31'd196608;
  localparam logic [30:0] P_INIT_RST = 31'd65536;

  typedef struct packed {
    logic signed [31:0] sample;
    logic               start_req;
  } kfj_in_t;

  typedef struct packed {
    logic signed [31:0] prior_position;
    logic [30:0]        abs_error;
    logic signed [31:0] next_forecast;
    logic               saturated;
  } kfj_out_t;

  // Divider status back to the sequencer
  typedef struct packed {
    logic done;
    logic sat;
  } kfj_div_stat_t;

endpackage

FILE: sv/kalman_filter_jerk_model.sv
// Four-state constant-jerk Kalman filter, position measurement, fixed point.
// Input channel (in_valid_i / in_stall_o): one sample per transfer; start_req
// reloads the state from the sample and the covariance from p_initial.
// Output channel (out_valid_o / out_stall_i): one result per sample with the
// prior position, its absolute error, the next-step forecast and a flag set
// when any clamp occurred.
// Config channel (cfg_valid_i / cfg_ready_o, always ready): write register
// cfg_index_i with cfg_data_i; unknown indexes are ignored. Write only idle.
// Operation: one shared multiplier forms every product in two steps (operand,
// then accumulate), 168 products per sample, plus four divisions on a
// bit-serial divider. The next sample is taken once the sequencer returns
// to idle.
// A finished result sits in the output register; the next sample may be
// transferred while it waits, but its own result waits for that register.
// Reset clears state vector and covariance, loads register defaults, and
// leaves the output channel empty.
module kalman_filter_jerk_model #(
  parameter int WORD_BITS = kfj_pkg::WORD_BITS_DEF,
  parameter int FRAC_BITS = kfj_pkg::FRAC_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  kfj_pkg::kfj_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output kfj_pkg::kfj_out_t out_data_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [2:0]        cfg_index_i,
  input  logic [30:0]       cfg_data_i
);

  localparam int ACC_W = ((WORD_BITS > 32) ? WORD_BITS : 32) + 3;
  localparam int SIXTH = ((2 ** FRAC_BITS) + 3) / 6;

  localparam logic signed [WORD_BITS-1:0] ONE_Q   = WORD_BITS'(1) << FRAC_BITS;
  localparam logic signed [WORD_BITS-1:0] HALF_Q  = WORD_BITS'(1) << (FRAC_BITS - 1);
  localparam logic signed [WORD_BITS-1:0] SIXTH_Q = WORD_BITS'(SIXTH);

  localparam logic signed [ACC_W-1:0] WMAX_A =
    {{(ACC_W-WORD_BITS+1){1'b0}}, {(WORD_BITS-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] WMIN_A = ~WMAX_A;
  localparam logic signed [ACC_W-1:0] OMAX_A = {{(ACC_W-31){1'b0}}, {31{1'b1}}};
  localparam logic signed [ACC_W-1:0] OMIN_A = ~OMAX_A;

  typedef enum logic [3:0] {
    S_IDLE, S_XP, S_AM, S_PM, S_PREP, S_DIV, S_XU, S_PU, S_FC, S_OUT
  } state_e;

  // word clamp helpers
  function automatic logic ovf_w(input logic signed [ACC_W-1:0] v);
    return (v > WMAX_A) || (v < WMIN_A);
  endfunction

  function automatic logic signed [WORD_BITS-1:0] clip_w(input logic signed [ACC_W-1:0] v);
    logic signed [WORD_BITS-1:0] r;
    if (v > WMAX_A) r = WMAX_A[WORD_BITS-1:0];
    else if (v < WMIN_A) r = WMIN_A[WORD_BITS-1:0];
    else r = v[WORD_BITS-1:0];
    return r;
  endfunction

  function automatic logic signed [31:0] clip_o(input logic signed [ACC_W-1:0] v);
    logic signed [31:0] r;
    if (v > OMAX_A) r = OMAX_A[31:0];
    else if (v < OMIN_A) r = OMIN_A[31:0];
    else r = v[31:0];
    return r;
  endfunction

  // transition matrix entry F(i,k)
  function automatic logic signed [WORD_BITS-1:0] tr(input logic [1:0] i,
                                                     input logic [1:0] k);
    logic signed [WORD_BITS-1:0] r;
    case ({i, k})
      4'h0, 4'h1, 4'h5, 4'h6, 4'ha, 4'hb, 4'hf: r = ONE_Q;
      4'h2, 4'h7:                               r = HALF_Q;
      4'h3:                                     r = SIXTH_Q;
      default:                                  r = '0;
    endcase
    return r;
  endfunction

  function automatic logic signed [ACC_W-1:0] ext(input logic signed [WORD_BITS-1:0] v);
    return ACC_W'(v);
  endfunction

  state_e state_q;
  logic [1:0] i_q, j_q, k_q;
  logic       sub_q, sat_q;

  logic [30:0] q_q [4];
  logic [30:0] r_q, pinit_q;

  logic signed [WORD_BITS-1:0] x_q [4];
  logic signed [WORD_BITS-1:0] p_q [16];
  logic signed [WORD_BITS-1:0] xp_q [4];
  logic signed [WORD_BITS-1:0] a_q [16];
  logic signed [WORD_BITS-1:0] pp_q [16];
  logic signed [WORD_BITS-1:0] gain_q [4];
  logic signed [WORD_BITS-1:0] z_q, y_q, s_q, fc_q;
  logic [30:0]                 err_q;
  logic signed [ACC_W-1:0]     acc_q;

  logic                    out_valid_q;
  kfj_pkg::kfj_out_t       out_q;

  logic signed [WORD_BITS-1:0] mul_a, mul_b, mul_p;
  logic                        mul_sat;
  logic                        div_start;
  logic signed [WORD_BITS-1:0] div_q;
  kfj_pkg::kfj_div_stat_t      div_stat;

  logic signed [ACC_W-1:0] base, sum, upd, zin, diff, absd;
  logic signed [ACC_W-1:0] y_a, s_a, pi_a;
  logic                    in_acc, out_free;

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign cfg_ready_o = 1'b1;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign div_start   = (state_q == S_DIV) && !sub_q;

  // operand select for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_XP: begin mul_a = tr(i_q, k_q);       mul_b = x_q[k_q];            end
      S_AM: begin mul_a = tr(i_q, k_q);       mul_b = p_q[{k_q, j_q}];     end
      S_PM: begin mul_a = a_q[{i_q, k_q}];    mul_b = tr(j_q, k_q);        end
      S_XU: begin mul_a = gain_q[i_q];        mul_b = y_q;                 end
      S_PU: begin mul_a = gain_q[i_q];        mul_b = pp_q[{2'b00, j_q}];  end
      S_FC: begin mul_a = tr(2'd0, k_q);      mul_b = x_q[k_q];            end
      default: begin mul_a = '0;              mul_b = '0;                  end
    endcase
  end

  // accumulate and scalar datapath
  always_comb begin
    if (k_q != 2'd0) base = acc_q;
    else if (state_q == S_PM && i_q == j_q) base = $signed(ACC_W'(q_q[i_q]));
    else base = '0;
    sum  = base + ext(mul_p);
    if (state_q == S_XU) upd = ext(xp_q[i_q]) + ext(mul_p);
    else upd = ext(pp_q[{i_q, j_q}]) - ext(mul_p);
    zin  = ACC_W'(in_data_i.sample);
    pi_a = $signed(ACC_W'(pinit_q));
    diff = ext(xp_q[0]) - ext(z_q);
    absd = diff[ACC_W-1] ? -diff : diff;
    y_a  = ext(z_q) - ext(xp_q[0]);
    s_a  = ext(pp_q[0]) + $signed(ACC_W'(r_q));
  end

  kfj_mul #(.WORD_BITS(WORD_BITS), .FRAC_BITS(FRAC_BITS)) u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p),
    .sat_o (mul_sat)
  );

  kfj_div #(.WORD_BITS(WORD_BITS), .FRAC_BITS(FRAC_BITS)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .a_i     (pp_q[{i_q, 2'b00}]),
    .d_i     (s_q),
    .q_o     (div_q),
    .stat_o  (div_stat)
  );

  // sequencer, state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      i_q         <= '0;
      j_q         <= '0;
      k_q         <= '0;
      sub_q       <= 1'b0;
      sat_q       <= 1'b0;
      out_valid_q <= 1'b0;
      q_q[0]      <= kfj_pkg::Q_POS_RST;
      q_q[1]      <= kfj_pkg::Q_VEL_RST;
      q_q[2]      <= kfj_pkg::Q_ACC_RST;
      q_q[3]      <= kfj_pkg::Q_JERK_RST;
      r_q         <= kfj_pkg::R_MEAS_RST;
      pinit_q     <= kfj_pkg::P_INIT_RST;
      for (int n = 0; n < 4; n++) x_q[n] <= '0;
      for (int n = 0; n < 16; n++) p_q[n] <= '0;
    end else begin
      // config writes
      if (cfg_valid_i) begin
        case (cfg_index_i)
          kfj_pkg::CFG_Q_POS:  q_q[0]  <= cfg_data_i;
          kfj_pkg::CFG_Q_VEL:  q_q[1]  <= cfg_data_i;
          kfj_pkg::CFG_Q_ACC:  q_q[2]  <= cfg_data_i;
          kfj_pkg::CFG_Q_JERK: q_q[3]  <= cfg_data_i;
          kfj_pkg::CFG_R_MEAS: r_q     <= cfg_data_i;
          kfj_pkg::CFG_P_INIT: pinit_q <= cfg_data_i;
          default: ;
        endcase
      end

      // result transfer frees the register; S_OUT refills it itself
      if (out_valid_q && !out_stall_i && state_q != S_OUT) out_valid_q <= 1'b0;

      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            z_q   <= clip_w(zin);
            sat_q <= ovf_w(zin) || (in_data_i.start_req && ovf_w(pi_a));
            if (in_data_i.start_req) begin
              x_q[0] <= clip_w(zin);
              for (int n = 1; n < 4; n++) x_q[n] <= '0;
              p_q[0] <= clip_w(pi_a);
              for (int n = 1; n < 16; n++) p_q[n] <= '0;
            end
            state_q <= S_XP;
          end
        end

        // matrix-vector and matrix-matrix products, one term per operand/accumulate pair
        S_XP, S_AM, S_PM, S_FC: begin
          sub_q <= ~sub_q;
          if (sub_q) begin
            sat_q <= sat_q | mul_sat | ((k_q == 2'd3) && ovf_w(sum));
            acc_q <= sum;
            k_q   <= k_q + 1'b1;
            if (k_q == 2'd3) begin
              case (state_q)
                S_XP: begin
                  xp_q[i_q] <= clip_w(sum);
                  i_q <= i_q + 1'b1;
                  if (i_q == 2'd3) state_q <= S_AM;
                end
                S_FC: begin
                  fc_q    <= clip_w(sum);
                  state_q <= S_OUT;
                end
                default: begin
                  if (state_q == S_AM) a_q[{i_q, j_q}] <= clip_w(sum);
                  else pp_q[{i_q, j_q}] <= clip_w(sum);
                  j_q <= j_q + 1'b1;
                  if (j_q == 2'd3) begin
                    i_q <= i_q + 1'b1;
                    if (i_q == 2'd3) state_q <= (state_q == S_AM) ? S_PM : S_PREP;
                  end
                end
              endcase
            end
          end
        end

        // innovation, its variance and the error report
        S_PREP: begin
          y_q   <= clip_w(y_a);
          s_q   <= clip_w(s_a);
          err_q <= (absd > OMAX_A) ? 31'h7fffffff : absd[30:0];
          if (ovf_w(y_a) || ovf_w(s_a) || absd > OMAX_A || clip_w(s_a) <= 0) begin
            sat_q <= 1'b1;
          end
          if (clip_w(s_a) <= 0) begin
            for (int n = 0; n < 4; n++) gain_q[n] <= '0;
            state_q <= S_XU;
          end else begin
            state_q <= S_DIV;
          end
        end

        // gains, one division each
        S_DIV: begin
          sub_q <= 1'b1;
          if (sub_q && div_stat.done) begin
            gain_q[i_q] <= div_q;
            sat_q       <= sat_q | div_stat.sat;
            sub_q       <= 1'b0;
            i_q         <= i_q + 1'b1;
            if (i_q == 2'd3) state_q <= S_XU;
          end
        end

        // state and covariance update
        S_XU, S_PU: begin
          sub_q <= ~sub_q;
          if (sub_q) begin
            sat_q <= sat_q | mul_sat | ovf_w(upd);
            if (state_q == S_XU) begin
              x_q[i_q] <= clip_w(upd);
              i_q <= i_q + 1'b1;
              if (i_q == 2'd3) state_q <= S_PU;
            end else begin
              p_q[{i_q, j_q}] <= clip_w(upd);
              j_q <= j_q + 1'b1;
              if (j_q == 2'd3) begin
                i_q <= i_q + 1'b1;
                if (i_q == 2'd3) state_q <= S_FC;
              end
            end
          end
        end

        // hand the result to the output register
        S_OUT: begin
          if (out_free) begin
            out_q.prior_position <= clip_o(ext(xp_q[0]));
            out_q.abs_error      <= err_q;
            out_q.next_forecast  <= clip_o(ext(fc_q));
            out_q.saturated      <= sat_q
                                    || ext(xp_q[0]) > OMAX_A || ext(xp_q[0]) < OMIN_A
                                    || ext(fc_q) > OMAX_A || ext(fc_q) < OMIN_A;
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end

        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: sv/kfj_mul.sv
// Shared fixed-point multiplier: round to nearest (ties away), clamp, register.
module kfj_mul #(
  parameter int WORD_BITS = kfj_pkg::WORD_BITS_DEF,
  parameter int FRAC_BITS = kfj_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic signed [WORD_BITS-1:0] a_i,
  input  logic signed [WORD_BITS-1:0] b_i,
  output logic signed [WORD_BITS-1:0] p_o,
  output logic                        sat_o
);

  localparam int PW = 2 * WORD_BITS + 1;

  logic                 neg;
  logic [WORD_BITS-1:0] ma, mb;
  logic [PW-1:0]        prod, rnd, sh, lim;
  logic                 ovf;
  logic [WORD_BITS-1:0] wmax, wmin;

  always_comb begin
    neg  = a_i[WORD_BITS-1] ^ b_i[WORD_BITS-1];
    ma   = a_i[WORD_BITS-1] ? WORD_BITS'(-a_i) : WORD_BITS'(a_i);
    mb   = b_i[WORD_BITS-1] ? WORD_BITS'(-b_i) : WORD_BITS'(b_i);
    prod = PW'(ma) * PW'(mb);
    rnd  = prod + (PW'(1) << (FRAC_BITS - 1));
    sh   = rnd >> FRAC_BITS;
    wmax = {1'b0, {(WORD_BITS-1){1'b1}}};
    wmin = {1'b1, {(WORD_BITS-1){1'b0}}};
    lim  = neg ? PW'(wmin) : PW'(wmax);
    ovf  = sh > lim;
  end

  always_ff @(posedge clk_i) begin
    sat_o <= ovf;
    if (ovf) begin
      p_o <= neg ? wmin : wmax;
    end else begin
      p_o <= neg ? -sh[WORD_BITS-1:0] : sh[WORD_BITS-1:0];
    end
  end

endmodule

FILE: sv/kfj_div.sv
// Restoring divider, one quotient bit per cycle: a / d in fixed point, d > 0.
module kfj_div #(
  parameter int WORD_BITS = kfj_pkg::WORD_BITS_DEF,
  parameter int FRAC_BITS = kfj_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic signed [WORD_BITS-1:0] a_i,
  input  logic signed [WORD_BITS-1:0] d_i,
  output logic signed [WORD_BITS-1:0] q_o,
  output kfj_pkg::kfj_div_stat_t      stat_o
);

  localparam int NW = WORD_BITS + FRAC_BITS;
  localparam int CW = $clog2(NW + 1);

  typedef enum logic [1:0] {D_IDLE, D_RUN, D_FIN} dstate_e;

  dstate_e              state_q;
  logic [CW-1:0]        cnt_q;
  logic [NW-1:0]        n_q, quo_q;
  logic [WORD_BITS:0]   rem_q, rem_sh, rem_d;
  logic [WORD_BITS-1:0] d_q, ma;
  logic                 neg_q, qbit;
  logic                 rnd;
  logic [NW:0]          qr, lim;
  logic                 ovf;
  logic [WORD_BITS-1:0] wmax, wmin;

  always_comb begin
    ma     = a_i[WORD_BITS-1] ? WORD_BITS'(-a_i) : WORD_BITS'(a_i);
    rem_sh = {rem_q[WORD_BITS-1:0], n_q[NW-1]};
    qbit   = rem_sh >= {1'b0, d_q};
    rem_d  = qbit ? rem_sh - {1'b0, d_q} : rem_sh;
    // round half up on the remainder, then clamp
    rnd    = {rem_q, 1'b0} >= {2'b00, d_q};
    qr     = {1'b0, quo_q} + (NW+1)'(rnd);
    wmax   = {1'b0, {(WORD_BITS-1){1'b1}}};
    wmin   = {1'b1, {(WORD_BITS-1){1'b0}}};
    lim    = neg_q ? (NW+1)'(wmin) : (NW+1)'(wmax);
    ovf    = qr > lim;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= D_IDLE;
      stat_o.done <= 1'b0;
      stat_o.sat  <= 1'b0;
      cnt_q       <= '0;
    end else begin
      stat_o.done <= 1'b0;
      case (state_q)
        D_IDLE: begin
          if (start_i) begin
            n_q     <= NW'(ma) << FRAC_BITS;
            quo_q   <= '0;
            rem_q   <= '0;
            d_q     <= d_i;
            neg_q   <= a_i[WORD_BITS-1];
            cnt_q   <= CW'(NW);
            state_q <= D_RUN;
          end
        end
        D_RUN: begin
          rem_q <= rem_d;
          n_q   <= n_q << 1;
          quo_q <= {quo_q[NW-2:0], qbit};
          cnt_q <= cnt_q - 1'b1;
          if (cnt_q == CW'(1)) begin
            state_q <= D_FIN;
          end
        end
        D_FIN: begin
          stat_o.done <= 1'b1;
          stat_o.sat  <= ovf;
          if (ovf) begin
            q_o <= neg_q ? wmin : wmax;
          end else begin
            q_o <= neg_q ? -qr[WORD_BITS-1:0] : qr[WORD_BITS-1:0];
          end
          state_q <= D_IDLE;
        end
        default: state_q <= D_IDLE;
      endcase
    end
  end

endmodule
